FILE: hdl/vehicle_immobilizer_lock_controller_core_assert.svh
// assertion macros for the immobilizer lock controller
`ifndef VEHICLE_IMMOBILIZER_LOCK_CONTROLLER_CORE_ASSERT_SVH
`define VEHICLE_IMMOBILIZER_LOCK_CONTROLLER_CORE_ASSERT_SVH

// same-cycle implication, clocked on clk_i, quiet during reset
`define VILC_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("vilc assertion failed");

// next-cycle implication
`define VILC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("vilc assertion failed");

`endif

FILE: hdl/vilc_pkg.sv
// types, constants and helpers shared by the lock controller
`timescale 1ns / 1ps

package vilc_pkg;

  localparam int CodeMaxLen  = 8;
  localparam int ButtonCount = 8;
  localparam int EntW        = $clog2(CodeMaxLen + 1);
  localparam int IdxW        = (CodeMaxLen > 1) ? $clog2(CodeMaxLen) : 1;
  localparam int CodeBits    = CodeMaxLen * 3;

  localparam logic [15:0] FreeTries = 16'd5;
  localparam logic [15:0] WrongMax  = 16'hFFFF;
  localparam logic [31:0] Backoff1  = 32'd15000;
  localparam logic [31:0] Backoff2  = 32'd30000;
  localparam logic [31:0] Backoff3  = 32'd60000;
  localparam logic [31:0] QuietMs   = 32'd300000;

  typedef enum logic [1:0] {
    ModeDisabled = 2'd0,
    ModeUnlocked = 2'd1,
    ModeParked   = 2'd2,
    ModeLocked   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ReqTick  = 3'd0,
    ReqPress = 3'd1,
    ReqLock  = 3'd2,
    ReqPhone = 3'd3,
    ReqBoot  = 3'd4
  } req_e;

  typedef enum logic [2:0] {
    StatOk       = 3'd0,
    StatUnauth   = 3'd1,
    StatRejected = 3'd2,
    StatPending  = 3'd3,
    StatNoCode   = 3'd4,
    StatBackoff  = 3'd5,
    StatMatch    = 3'd6,
    StatMismatch = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    IgnNone = 2'd0,
    IgnOff  = 2'd1,
    IgnOn   = 2'd2
  } ign_cmd_e;

  typedef enum logic [3:0] {
    CfgEnable     = 4'd0,
    CfgMethod     = 4'd1,
    CfgIgnPresent = 4'd2,
    CfgGrace      = 4'd3,
    CfgWindow     = 4'd4,
    CfgCodeLen    = 4'd5,
    CfgCodeDigits = 4'd6,
    CfgBootLocked = 4'd7
  } cfg_idx_e;

  typedef struct packed {
    logic        immobilizer_enable;
    logic [1:0]  method_bits;
    logic        ignition_present;
    logic [31:0] grace_ms;
    logic [31:0] window_ms;
    logic [3:0]  code_length;
    logic [23:0] code_digits;
    logic        boot_locked;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] time_ms;
    logic [2:0]  button_id;
    logic        engine_on;
    logic        ignition_on;
    logic        switch_level;
  } req_t;

  typedef struct packed {
    logic [1:0] lock_state;
    logic       immobilized;
    logic [1:0] ignition_command;
    logic       sweep_off;
    logic       persist_request;
    logic [2:0] status_code;
  } res_t;

  // wrapping elapsed-time test
  function automatic logic elapsed(logic [31:0] now, logic [31:0] since, logic [31:0] dur);
    logic [31:0] diff;
    diff = now - since;
    return diff >= dur;
  endfunction

endpackage

FILE: hdl/vilc_req_if.sv
// event item channel
`timescale 1ns / 1ps

interface vilc_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [31:0] time_ms;
  logic [2:0]  button_id;
  logic        engine_on;
  logic        ignition_on;
  logic        switch_level;

  modport source (output valid, req_type, time_ms, button_id, engine_on, ignition_on,
                  switch_level, input ready);
  modport sink (input valid, req_type, time_ms, button_id, engine_on, ignition_on,
                switch_level, output ready);
endinterface

FILE: hdl/vilc_res_if.sv
// result item channel
`timescale 1ns / 1ps

interface vilc_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] lock_state;
  logic       immobilized;
  logic [1:0] ignition_command;
  logic       sweep_off;
  logic       persist_request;
  logic [2:0] status_code;

  modport source (output valid, lock_state, immobilized, ignition_command, sweep_off,
                  persist_request, status_code, input ready);
  modport sink (input valid, lock_state, immobilized, ignition_command, sweep_off,
                persist_request, status_code, output ready);
endinterface

FILE: hdl/vilc_cfg_if.sv
// configuration write channel
`timescale 1ns / 1ps

interface vilc_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/vilc_cfg_regs.sv
// configuration register file
`timescale 1ns / 1ps

module vilc_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  vilc_cfg_if.sink      cfg_i,
  output vilc_pkg::cfg_t cfg_o
);
  import vilc_pkg::*;

  cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CfgEnable:     cfg_q.immobilizer_enable <= cfg_i.data[0];
        CfgMethod:     cfg_q.method_bits        <= cfg_i.data[1:0];
        CfgIgnPresent: cfg_q.ignition_present   <= cfg_i.data[0];
        CfgGrace:      cfg_q.grace_ms           <= cfg_i.data;
        CfgWindow:     cfg_q.window_ms          <= cfg_i.data;
        CfgCodeLen:    cfg_q.code_length        <= cfg_i.data[3:0];
        CfgCodeDigits: cfg_q.code_digits        <= cfg_i.data[23:0];
        CfgBootLocked: cfg_q.boot_locked        <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

endmodule

FILE: hdl/vilc_ctrl.sv
// lock state, code entry and backoff state with their update logic
`timescale 1ns / 1ps

module vilc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           upd_i,
  input  vilc_pkg::req_t req_i,
  input  vilc_pkg::cfg_t cfg_i,
  output vilc_pkg::res_t res_o
);
  import vilc_pkg::*;

  mode_e              mode_q, mode_d;
  logic               locked_q, locked_d;
  logic [EntW-1:0]    ecnt_q, ecnt_d;
  logic [2:0]         ebtn_q [CodeMaxLen];
  logic [2:0]         ebtn_d [CodeMaxLen];
  logic [31:0]        estart_q, estart_d;
  logic [15:0]        wrong_q, wrong_d;
  logic [31:0]        bend_q, bend_d;
  logic               bon_q, bon_d;
  logic [31:0]        last_q, last_d;
  logic [31:0]        pstart_q, pstart_d;
  logic               prev_q, prev_d;
  ign_cmd_e           cmd;
  status_e            status;
  logic               sweep, persist;

  always_comb begin
    logic                   ign;
    logic                   sw_meth;
    logic                   guard;
    logic                   bon;
    logic                   match;
    logic                   ovr;
    logic [EntW-1:0]        cnt;
    logic [15:0]            wrong;
    logic [31:0]            dur;
    logic [CodeBits+23:0]   code_ext;

    mode_d   = mode_q;
    locked_d = locked_q;
    ecnt_d   = ecnt_q;
    ebtn_d   = ebtn_q;
    estart_d = estart_q;
    wrong_d  = wrong_q;
    bend_d   = bend_q;
    bon_d    = bon_q;
    last_d   = last_q;
    pstart_d = pstart_q;
    prev_d   = prev_q;
    cmd      = IgnNone;
    status   = StatOk;
    sweep    = 1'b0;
    persist  = 1'b0;

    ign      = cfg_i.ignition_present & req_i.ignition_on;
    sw_meth  = cfg_i.method_bits[1];
    guard    = 1'b0;
    bon      = bon_q;
    match    = 1'b0;
    ovr      = 1'b0;
    cnt      = ecnt_q;
    wrong    = wrong_q;
    dur      = '0;
    code_ext = {{CodeBits{1'b0}}, cfg_i.code_digits};

    case (req_i.req_type)
      ReqTick: begin
        if (bon && req_i.time_ms >= bend_q) bon = 1'b0;
        bon_d = bon;
        if (wrong_q != '0 && !bon && elapsed(req_i.time_ms, last_q, QuietMs)) wrong_d = '0;
        if (ecnt_q != '0 && elapsed(req_i.time_ms, estart_q, cfg_i.window_ms)) ecnt_d = '0;
        if (!cfg_i.immobilizer_enable) begin
          if (mode_q != ModeDisabled) begin
            mode_d   = ModeDisabled;
            locked_d = 1'b0;
            persist  = locked_q;
            if (mode_q == ModeLocked) begin
              ecnt_d  = '0;
              wrong_d = '0;
              bend_d  = '0;
              bon_d   = 1'b0;
            end
          end
        end else begin
          prev_d = req_i.switch_level;
          if (sw_meth && (req_i.switch_level != prev_q) && mode_q != ModeLocked &&
              cfg_i.ignition_present && (req_i.switch_level != ign)) begin
            cmd = req_i.switch_level ? IgnOn : IgnOff;
            ign = req_i.switch_level;
          end
          guard = !req_i.engine_on && !ign;
          case (mode_q)
            ModeDisabled: mode_d = ModeUnlocked;
            ModeUnlocked: begin
              if (guard) begin
                mode_d   = ModeParked;
                pstart_d = req_i.time_ms;
              end
            end
            ModeParked: begin
              if (!guard) begin
                mode_d = ModeUnlocked;
              end else if (elapsed(req_i.time_ms, pstart_q, cfg_i.grace_ms)) begin
                mode_d   = ModeLocked;
                locked_d = 1'b1;
                persist  = !locked_q;
                sweep    = 1'b1;
              end
            end
            default: begin
              if (req_i.switch_level && sw_meth) begin
                mode_d   = ModeUnlocked;
                locked_d = 1'b0;
                persist  = locked_q;
                ecnt_d   = '0;
                wrong_d  = '0;
                bend_d   = '0;
                bon_d    = 1'b0;
                if (cfg_i.ignition_present) cmd = IgnOn;
              end
            end
          endcase
        end
      end
      ReqPress: begin
        if (mode_q != ModeLocked) begin
          status = StatPending;
        end else if (cfg_i.code_length == '0) begin
          status = StatNoCode;
        end else if (bon_q) begin
          status = StatBackoff;
        end else if (32'(req_i.button_id) >= ButtonCount) begin
          status = StatPending;
        end else begin
          if (ecnt_q == '0 || elapsed(req_i.time_ms, estart_q, cfg_i.window_ms)) begin
            cnt      = '0;
            estart_d = req_i.time_ms;
          end
          if (32'(cnt) < CodeMaxLen) begin
            ebtn_d[cnt[IdxW-1:0]] = req_i.button_id;
            cnt = cnt + 1'b1;
          end
          if (32'(cnt) < 32'(cfg_i.code_length)) begin
            ecnt_d = cnt;
            status = StatPending;
          end else begin
            match = (32'(cnt) == 32'(cfg_i.code_length));
            for (int i = 0; i < CodeMaxLen; i++) begin
              if (i < 32'(cnt) && ebtn_d[i] != code_ext[3*i +: 3]) match = 1'b0;
            end
            ecnt_d = '0;
            last_d = req_i.time_ms;
            if (match) begin
              status   = StatMatch;
              mode_d   = ModeUnlocked;
              locked_d = 1'b0;
              persist  = locked_q;
              wrong_d  = '0;
              bend_d   = '0;
              bon_d    = 1'b0;
              if (cfg_i.ignition_present) cmd = IgnOn;
            end else begin
              status = StatMismatch;
              if (wrong_q < WrongMax) wrong = wrong_q + 16'd1;
              wrong_d = wrong;
              if (wrong <= FreeTries) dur = '0;
              else if (wrong == FreeTries + 16'd1) dur = Backoff1;
              else if (wrong == FreeTries + 16'd2) dur = Backoff2;
              else dur = Backoff3;
              if (dur != '0) begin
                bend_d = req_i.time_ms + dur;
                bon_d  = 1'b1;
              end
            end
          end
        end
      end
      ReqLock: begin
        if (!cfg_i.immobilizer_enable) begin
          status = StatUnauth;
        end else if (mode_q == ModeLocked) begin
          status = StatOk;
        end else if (req_i.engine_on || ign) begin
          status = StatRejected;
        end else begin
          mode_d   = ModeLocked;
          locked_d = 1'b1;
          persist  = !locked_q;
          sweep    = 1'b1;
        end
      end
      ReqPhone: begin
        if (mode_q != ModeLocked) begin
          status = StatOk;
        end else if (!cfg_i.method_bits[0]) begin
          status = StatUnauth;
        end else begin
          mode_d   = ModeUnlocked;
          locked_d = 1'b0;
          persist  = locked_q;
          ecnt_d   = '0;
          wrong_d  = '0;
          bend_d   = '0;
          bon_d    = 1'b0;
          if (cfg_i.ignition_present) cmd = IgnOn;
        end
      end
      ReqBoot: begin
        mode_d   = ModeDisabled;
        locked_d = 1'b0;
        ecnt_d   = '0;
        estart_d = '0;
        wrong_d  = '0;
        bend_d   = '0;
        bon_d    = 1'b0;
        last_d   = '0;
        pstart_d = '0;
        prev_d   = 1'b0;
        if (cfg_i.immobilizer_enable) begin
          ovr = cfg_i.boot_locked && (req_i.engine_on || ign);
          if (cfg_i.boot_locked && !ovr) begin
            mode_d   = ModeLocked;
            locked_d = 1'b1;
            sweep    = 1'b1;
          end else begin
            mode_d  = ModeUnlocked;
            persist = ovr;
          end
        end
      end
      default: ;
    endcase

    res_o.lock_state       = mode_d;
    res_o.immobilized      = (mode_d == ModeLocked);
    res_o.ignition_command = cmd;
    res_o.sweep_off        = sweep;
    res_o.persist_request  = persist;
    res_o.status_code      = status;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ModeDisabled;
      locked_q <= 1'b0;
      ecnt_q   <= '0;
      estart_q <= '0;
      wrong_q  <= '0;
      bend_q   <= '0;
      bon_q    <= 1'b0;
      last_q   <= '0;
      pstart_q <= '0;
      prev_q   <= 1'b0;
    end else if (upd_i) begin
      mode_q   <= mode_d;
      locked_q <= locked_d;
      ecnt_q   <= ecnt_d;
      estart_q <= estart_d;
      wrong_q  <= wrong_d;
      bend_q   <= bend_d;
      bon_q    <= bon_d;
      last_q   <= last_d;
      pstart_q <= pstart_d;
      prev_q   <= prev_d;
    end
  end

  // entry buttons, no reset
  always_ff @(posedge clk_i) begin
    if (upd_i) ebtn_q <= ebtn_d;
  end

`include "vehicle_immobilizer_lock_controller_core_assert.svh"

  `VILC_ASSERT(a_mark_tracks_mode, 1'b1, locked_q == (mode_q == ModeLocked))
  `VILC_ASSERT(a_sweep_only_locked, upd_i && sweep, mode_d == ModeLocked)
  `VILC_ASSERT(a_persist_flips_mark, upd_i && persist && (req_i.req_type != ReqBoot), locked_d != locked_q)
  `VILC_ASSERT_NXT(a_match_unlocks, upd_i && (status == StatMatch),
                   (mode_q == ModeUnlocked) && (wrong_q == '0) && !bon_q)

endmodule

FILE: hdl/vehicle_immobilizer_lock_controller_core.sv
// Immobilizer lock controller top level. One event item is taken per clock
// cycle while the output side keeps up; a result that waits at the output lets
// one more item into the input register and then holds the input off. Each
// item goes into an input register, is evaluated by combinational
// compare-and-update logic on the lock, code entry and backoff state, and its
// result is held in an output register, from which it is presented until the
// output side takes it. The rate is set by the state update, which the next
// item reads straight away. The configuration port is always ready and needs
// no clearing pass after reset.
`timescale 1ns / 1ps

module vehicle_immobilizer_lock_controller_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  vilc_req_if.sink  req_i,
  vilc_res_if.source res_o,
  vilc_cfg_if.sink  cfg_i
);
  import vilc_pkg::*;

  cfg_t cfg;
  req_t ireq_q;
  logic iv_q;
  res_t res_d, res_q;
  logic ov_q;
  logic upd;

  assign upd         = iv_q && (!ov_q || res_o.ready);
  assign req_i.ready = !iv_q || upd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (req_i.ready) iv_q <= req_i.valid;
      if (upd) ov_q <= 1'b1;
      else if (res_o.ready) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      ireq_q.req_type     <= req_i.req_type;
      ireq_q.time_ms      <= req_i.time_ms;
      ireq_q.button_id    <= req_i.button_id;
      ireq_q.engine_on    <= req_i.engine_on;
      ireq_q.ignition_on  <= req_i.ignition_on;
      ireq_q.switch_level <= req_i.switch_level;
    end
    if (upd) res_q <= res_d;
  end

  vilc_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  vilc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .upd_i  (upd),
    .req_i  (ireq_q),
    .cfg_i  (cfg),
    .res_o  (res_d)
  );

  assign res_o.valid            = ov_q;
  assign res_o.lock_state       = res_q.lock_state;
  assign res_o.immobilized      = res_q.immobilized;
  assign res_o.ignition_command = res_q.ignition_command;
  assign res_o.sweep_off        = res_q.sweep_off;
  assign res_o.persist_request  = res_q.persist_request;
  assign res_o.status_code      = res_q.status_code;

endmodule
